/* hw/rtl/trt_pkg.sv */
// Package for the tuple record table: field widths, operation and status codes,
// and the stored record type. No dependencies; every other file depends on it.
package trt_pkg;

   // Field widths of the request and response transfers
   localparam int unsigned OP_W      = 3;
   localparam int unsigned STUDENT_W = 24;
   localparam int unsigned COURSE_W  = 16;
   localparam int unsigned TERM_W    = 16;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned POS_W     = 5;
   localparam int unsigned LIST_W    = 24;
   localparam int unsigned COUNT_W   = 6;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
   localparam logic [OP_W-1:0] OP_DROP     = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd3;
   localparam logic [OP_W-1:0] OP_ROSTER   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // One table entry
   typedef struct packed {
      logic [STUDENT_W-1:0] student_id;
      logic [COURSE_W-1:0]  course_id;
      logic [TERM_W-1:0]    term_code;
   } record_type;

endpackage

/* hw/rtl/trt_req_if.sv */
// Request channel of the tuple record table: valid/ready plus operation and keys.
// Depends on trt_pkg for the field widths.
interface trt_req_if;
   logic                             valid;
   logic                             ready;
   logic [trt_pkg::OP_W-1:0]         operation;
   logic [trt_pkg::STUDENT_W-1:0]    student_id;
   logic [trt_pkg::COURSE_W-1:0]     course_id;
   logic [trt_pkg::TERM_W-1:0]       term_code;

   modport source (output valid, output operation, output student_id,
                   output course_id, output term_code, input ready);
   modport sink   (input valid, input operation, input student_id,
                   input course_id, input term_code, output ready);
endinterface

/* hw/rtl/trt_rsp_if.sv */
// Response channel of the tuple record table: valid/ready plus result fields.
// Depends on trt_pkg for the field widths.
interface trt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [trt_pkg::STATUS_W-1:0]     status;
   logic [trt_pkg::POS_W-1:0]        position;
   logic [trt_pkg::LIST_W-1:0]       listed_id;
   logic [trt_pkg::COUNT_W-1:0]      match_count;
   logic                             last;

   modport source (output valid, output status, output position, output listed_id,
                   output match_count, output last, input ready);
   modport sink   (input valid, input status, input position, input listed_id,
                   input match_count, input last, output ready);
endinterface

/* hw/rtl/tuple_record_table_unit.sv */
// Tuple record table: an ordered, compacted table of (student, course, term) records.
// Depends on trt_pkg, trt_req_if and trt_rsp_if.
//
// The table sits in a single-port-read, single-port-write memory and a small
// sequencer walks it one entry per cycle through one shared key comparator,
// except that a listing holds on a match while the output register is busy. An
// item is taken only when the unit is idle. Drop scans up to the hit and then
// shifts each later entry down one place (read entry i+1, write entry i). Every
// operation ends with a closing result, which waits for the output register to
// free up. A result waits in an output register while the unit goes on; a
// listing emits one transfer per matching entry and then a closing transfer
// with the count.
module tuple_record_table_unit #(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input logic       clock,
   input logic       reset,
   trt_req_if.sink   req_chan,
   trt_rsp_if.source rsp_chan
);
   import trt_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH + 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_DONE  = 3'd3;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  hit_ff, hit_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  nlist_ff, nlist_in;
   logic [OP_W-1:0]   op_ff, op_in;
   record_type        key_ff, key_in;

   // Table memory with registered read
   record_type        mem_ff [TABLE_DEPTH];
   record_type        rd_q_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   record_type        wr_data;

   // Response output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [LIST_W-1:0]   rsp_list_ff, rsp_list_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   logic              rsp_load;
   logic              is_listing;
   logic              eq_student, eq_course, eq_term;
   logic              key_hit;
   logic              last_entry;
   logic              table_full;
   logic [IDX_W-1:0]  idx_next;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign is_listing     = (op_ff == OP_SCHEDULE) || (op_ff == OP_ROSTER);
   assign table_full     = (count_ff == IDX_W'(TABLE_DEPTH));
   assign idx_next       = idx_ff + IDX_W'(1);
   assign last_entry     = (idx_next == count_ff);

   // Shared key comparator; the operation selects which fields take part
   assign eq_student = (rd_q_ff.student_id == key_ff.student_id);
   assign eq_course  = (rd_q_ff.course_id == key_ff.course_id);
   assign eq_term    = (rd_q_ff.term_code == key_ff.term_code);
   always_comb begin
      case (op_ff)
         OP_SCHEDULE: key_hit = eq_term && eq_student;
         OP_ROSTER:   key_hit = eq_term && eq_course;
         default:     key_hit = eq_term && eq_student && eq_course;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      nlist_in      = nlist_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[ADDR_W-1:0];
      wr_data       = rd_q_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_pos_in    = '0;
      rsp_list_in   = '0;
      rsp_count_in  = '0;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               op_in            = req_chan.operation;
               key_in.student_id = req_chan.student_id;
               key_in.course_id  = req_chan.course_id;
               key_in.term_code  = req_chan.term_code;
               found_in         = 1'b0;
               hit_in           = '0;
               nlist_in         = '0;
               if (req_chan.operation inside {OP_DROP, OP_SEARCH, OP_SCHEDULE, OP_ROSTER}) begin
                  state_in = (count_ff == '0) ? S_DONE : S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_SCAN: begin
            if (is_listing) begin
               // stall on a match until the output register frees up
               if (!(key_hit && !out_free)) begin
                  if (key_hit) begin
                     rsp_load    = 1'b1;
                     rsp_list_in = (op_ff == OP_SCHEDULE) ?
                                   LIST_W'(rd_q_ff.course_id) :
                                   LIST_W'(rd_q_ff.student_id);
                     nlist_in    = nlist_ff + IDX_W'(1);
                  end
                  if (last_entry) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in = idx_next;
                  end
               end
            end else if (key_hit) begin
               found_in = 1'b1;
               hit_in   = idx_ff;
               if (op_ff == OP_DROP) begin
                  idx_in   = idx_next;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (last_entry) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_next;
            end
         end

         S_SHIFT: begin
            // rd_q_ff holds entry idx_ff; move it down one place
            if (idx_ff == count_ff) begin
               state_in = S_DONE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(idx_ff - IDX_W'(1));
               idx_in  = idx_next;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
               case (op_ff) inside
                  OP_ADD: begin
                     if (table_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = count_ff[ADDR_W-1:0];
                        wr_data     = key_ff;
                        rsp_pos_in  = POS_W'(count_ff);
                        count_in    = count_ff + IDX_W'(1);
                     end
                  end
                  OP_DROP, OP_SEARCH: begin
                     if (found_ff) begin
                        rsp_pos_in = POS_W'(hit_ff);
                        if (op_ff == OP_DROP) begin
                           count_in = count_ff - IDX_W'(1);
                        end
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  OP_SCHEDULE, OP_ROSTER: begin
                     rsp_count_in = COUNT_W'(nlist_ff);
                  end
                  default: begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load a result or drop it once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         nlist_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         nlist_ff     <= nlist_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      op_ff  <= op_in;
      key_ff <= key_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_list_ff   <= rsp_list_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem_ff[idx_in[ADDR_W-1:0]];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.position    = rsp_pos_ff;
   assign rsp_chan.listed_id   = rsp_list_ff;
   assign rsp_chan.match_count = rsp_count_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef SYNTHESIS
   // The table never holds more entries than it has room for
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // The scan pointer only visits filled entries
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff < count_ff))
      else $error("scan pointer past last entry");

   // A new result is never loaded over one still waiting to transfer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !rsp_load)
      else $error("pending result overwritten");

   // The entry count moves by at most one per item and only when leaving DONE
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(count_ff))
      else $error("entry count changed outside completion");
`endif

endmodule
